FILE: hdl/cdtn_pkg.sv
// Shared types, constants and calendar functions of the date and time normaliser.
`timescale 1ns / 1ps

package cdtn_pkg;

    // Calendar constants.
    localparam int C_SEC_PER_MIN  = 60;
    localparam int C_HOUR_PER_DAY = 24;
    localparam int C_CENTURY      = 100;
    localparam int C_YEAR_CYCLE   = 400;
    localparam int C_LEAP_FEB     = 29;
    localparam int C_YEAR_MAX     = 32767;

    // Month numbers that matter to the sequencing.
    localparam logic [3:0] C_MONTH_FIRST = 4'd1;
    localparam logic [3:0] C_MONTH_FEB   = 4'd2;
    localparam logic [3:0] C_MONTH_LAST  = 4'd12;

    // Widths of the working values.
    localparam int C_WIDE_W     = 17;   // carried minute, hour and day
    localparam int C_DIVIDEND_W = 17;   // biased dividend of the shared divider
    localparam int C_DIVISOR_W  = 9;    // largest divisor is the 400-year cycle
    localparam int C_YEAR_W     = 16;   // walked year, may pass the saturation limit
    localparam int C_YMOD_W     = 9;    // year modulo 400

    // Bias that lifts every dividend above zero; a multiple of 60, 24 and 400,
    // so the remainder is unchanged and the quotient carries a fixed offset.
    localparam int C_DIV_OFFSET = 36000;

    // Days of each month in a common year, January first.
    localparam logic [4:0] C_MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Which value the shared divider works on.
    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR,
        DIV_YEAR
    } t_div_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     walk;
        logic     out_load;
    } t_cdtn_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic fwd_need;
        logic bwd_need;
    } t_cdtn_sts;

    // Gregorian leap test on the year taken modulo 400.
    function automatic logic f_is_leap(input logic [C_YMOD_W-1:0] ymod);
        logic century;
        century = (ymod == C_YMOD_W'(C_CENTURY))
               || (ymod == C_YMOD_W'(2 * C_CENTURY))
               || (ymod == C_YMOD_W'(3 * C_CENTURY));
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month; month is 1 to 12.
    function automatic logic [4:0] f_days_of(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = C_MONTH_LEN[(month == 4'd0) ? 4'd0 : (month - 4'd1)];
        if (month == C_MONTH_FEB && leap) begin
            len = 5'(C_LEAP_FEB);
        end
        return len;
    endfunction

endpackage

FILE: hdl/cdtn_in_if.sv
// Input channel of the date and time normaliser: the raw date and time.
`timescale 1ns / 1ps

interface cdtn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] year_in;
    logic signed [15:0] month_in;
    logic signed [15:0] day_in;
    logic signed [15:0] hour_in;
    logic signed [15:0] minute_in;
    logic signed [15:0] second_in;

    modport source (
        output valid, year_in, month_in, day_in, hour_in, minute_in, second_in,
        input  ready
    );
    modport sink (
        input  valid, year_in, month_in, day_in, hour_in, minute_in, second_in,
        output ready
    );
endinterface

FILE: hdl/cdtn_out_if.sv
// Output channel of the date and time normaliser: the normalised date and time.
`timescale 1ns / 1ps

interface cdtn_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        year_saturated;

    modport source (
        output valid, year_out, month_out, day_out, hour_out, minute_out,
               second_out, year_saturated,
        input  ready
    );
    modport sink (
        input  valid, year_out, month_out, day_out, hour_out, minute_out,
               second_out, year_saturated,
        output ready
    );
endinterface

FILE: hdl/cdtn_div.sv
// Constant divider by reciprocal multiplication, three registered stages per transfer.
`timescale 1ns / 1ps

module cdtn_div import cdtn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [C_DIVIDEND_W-1:0] i_dividend,
    input  logic [C_DIVISOR_W-1:0]  i_divisor,
    output logic                    o_done,
    output logic [C_DIVIDEND_W-1:0] o_quot,
    output logic [C_DIVISOR_W-1:0]  o_rem
);

    // Reciprocals rounded up at a common scale of 2^26. For every dividend below
    // 2^17 the rounding error stays under one step, so the top product bits are
    // the exact quotient.
    localparam int C_SHIFT   = 26;
    localparam int C_RECIP_W = 22;
    localparam int C_PROD_W  = C_DIVIDEND_W + C_RECIP_W;
    localparam int C_QUOT_W  = C_PROD_W - C_SHIFT;

    localparam logic [C_RECIP_W-1:0] C_RECIP_MIN  = 22'd1118482;
    localparam logic [C_RECIP_W-1:0] C_RECIP_DAY  = 22'd2796203;
    localparam logic [C_RECIP_W-1:0] C_RECIP_YEAR = 22'd167773;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_done;
    logic [C_DIVIDEND_W-1:0] r_x;
    logic [C_DIVISOR_W-1:0]  r_dvs;
    logic [C_RECIP_W-1:0]    r_recip;
    logic [C_PROD_W-1:0]     r_prod;
    logic [C_QUOT_W-1:0]     r_quot;
    logic [C_DIVISOR_W-1:0]  r_rem;

    logic [C_RECIP_W-1:0]    s_recip;
    logic [C_QUOT_W-1:0]     s_quot;
    logic [C_DIVIDEND_W-1:0] s_back;
    logic [C_DIVIDEND_W-1:0] s_rem_wide;

    always_comb begin
        case (i_divisor)
            C_DIVISOR_W'(C_SEC_PER_MIN): begin
                s_recip = C_RECIP_MIN;
            end
            C_DIVISOR_W'(C_HOUR_PER_DAY): begin
                s_recip = C_RECIP_DAY;
            end
            default: begin
                s_recip = C_RECIP_YEAR;
            end
        endcase
    end

    assign s_quot     = r_prod[C_PROD_W-1:C_SHIFT];
    assign s_back     = C_DIVIDEND_W'(s_quot) * C_DIVIDEND_W'(r_dvs);
    assign s_rem_wide = r_x - s_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x     <= i_dividend;
            r_dvs   <= i_divisor;
            r_recip <= s_recip;
        end
        if (r_v1) begin
            r_prod <= C_PROD_W'(r_x) * C_PROD_W'(r_recip);
        end
        if (r_v2) begin
            r_quot <= s_quot;
            r_rem  <= s_rem_wide[C_DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = C_DIVIDEND_W'(r_quot);
    assign o_rem  = r_rem;

endmodule

FILE: hdl/cdtn_datapath.sv
// Datapath: working registers, time carries through the divider, month walk, result register.
`timescale 1ns / 1ps

module cdtn_datapath import cdtn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cdtn_cmd          i_cmd,
    input  logic signed [15:0] i_year_in,
    input  logic signed [15:0] i_month_in,
    input  logic signed [15:0] i_day_in,
    input  logic signed [15:0] i_hour_in,
    input  logic signed [15:0] i_minute_in,
    input  logic signed [15:0] i_second_in,
    output t_cdtn_sts          o_sts,
    output logic [14:0]        o_year_out,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_out,
    output logic [4:0]         o_hour_out,
    output logic [5:0]         o_minute_out,
    output logic [5:0]         o_second_out,
    output logic               o_year_saturated
);

    localparam int C_NUM_W     = C_WIDE_W + 1;
    localparam int C_QOFF_MIN  = C_DIV_OFFSET / C_SEC_PER_MIN;
    localparam int C_QOFF_DAY  = C_DIV_OFFSET / C_HOUR_PER_DAY;

    // Working registers.
    logic signed [15:0]         r_s;
    logic signed [C_WIDE_W-1:0] r_m;
    logic signed [C_WIDE_W-1:0] r_h;
    logic signed [C_WIDE_W-1:0] r_d;
    logic [3:0]                 r_month;
    logic [C_YEAR_W-1:0]        r_year;
    logic [C_YMOD_W-1:0]        r_ymod;
    logic [5:0]                 r_sec;
    logic [5:0]                 r_min;
    logic [4:0]                 r_hr;

    // Result register.
    logic [14:0] r_year_out;
    logic [3:0]  r_month_out;
    logic [4:0]  r_day_out;
    logic [4:0]  r_hour_out;
    logic [5:0]  r_minute_out;
    logic [5:0]  r_second_out;
    logic        r_sat_out;

    logic signed [C_NUM_W-1:0]  s_num;
    logic signed [C_NUM_W-1:0]  s_biased;
    logic [C_DIVISOR_W-1:0]     s_divisor;
    logic [C_DIVIDEND_W-1:0]    s_quot;
    logic [C_DIVISOR_W-1:0]     s_rem;
    logic                       s_div_done;
    logic signed [C_NUM_W-1:0]  s_q60;
    logic signed [C_NUM_W-1:0]  s_q24;

    logic [3:0]                 s_month_clamped;
    logic [C_YEAR_W-1:0]        s_year_clamped;

    logic [4:0]                 s_dim_cur;
    logic                       s_fwd_need;
    logic                       s_bwd_need;
    logic [3:0]                 s_bw_month;
    logic [C_YEAR_W-1:0]        s_bw_year;
    logic [C_YMOD_W-1:0]        s_bw_ymod;
    logic [4:0]                 s_dim_bw;

    // Operand of the shared divider, lifted above zero by the bias.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_SEC: begin
                s_num     = C_NUM_W'(r_s);
                s_divisor = C_DIVISOR_W'(C_SEC_PER_MIN);
            end
            DIV_MIN: begin
                s_num     = C_NUM_W'(r_m);
                s_divisor = C_DIVISOR_W'(C_SEC_PER_MIN);
            end
            DIV_HOUR: begin
                s_num     = C_NUM_W'(r_h);
                s_divisor = C_DIVISOR_W'(C_HOUR_PER_DAY);
            end
            default: begin
                s_num     = $signed({2'b00, r_year});
                s_divisor = C_DIVISOR_W'(C_YEAR_CYCLE);
            end
        endcase
        s_biased = s_num + C_NUM_W'(C_DIV_OFFSET);
    end

    cdtn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (s_biased[C_DIVIDEND_W-1:0]),
        .i_divisor  (s_divisor),
        .o_done     (s_div_done),
        .o_quot     (s_quot),
        .o_rem      (s_rem)
    );

    // Floor quotients once the bias is taken back out.
    assign s_q60 = $signed({1'b0, s_quot}) - C_NUM_W'(C_QOFF_MIN);
    assign s_q24 = $signed({1'b0, s_quot}) - C_NUM_W'(C_QOFF_DAY);

    // Clamps applied as the item is taken in.
    always_comb begin
        if (i_month_in < 16'sd1) begin
            s_month_clamped = C_MONTH_FIRST;
        end else if (i_month_in > 16'sd12) begin
            s_month_clamped = C_MONTH_LAST;
        end else begin
            s_month_clamped = i_month_in[3:0];
        end
        if (i_year_in < 16'sd1) begin
            s_year_clamped = C_YEAR_W'(1);
        end else begin
            s_year_clamped = C_YEAR_W'(i_year_in);
        end
    end

    // Month walk: forward while the day overruns its month, backward while
    // it is below one.
    assign s_dim_cur  = f_days_of(r_month, f_is_leap(r_ymod));
    assign s_fwd_need = (r_d > $signed(C_WIDE_W'(s_dim_cur)));
    assign s_bwd_need = r_d[C_WIDE_W-1] || (r_d == '0);

    always_comb begin
        s_bw_month = r_month - 4'd1;
        s_bw_year  = r_year;
        s_bw_ymod  = r_ymod;
        if (r_month == C_MONTH_FIRST) begin
            s_bw_month = C_MONTH_LAST;
            // The year never falls below one.
            if (r_year > C_YEAR_W'(1)) begin
                s_bw_year = r_year - C_YEAR_W'(1);
                s_bw_ymod = (r_ymod == '0) ? C_YMOD_W'(C_YEAR_CYCLE - 1)
                                           : r_ymod - C_YMOD_W'(1);
            end
        end
        s_dim_bw = f_days_of(s_bw_month, f_is_leap(s_bw_ymod));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s     <= i_second_in;
            r_m     <= C_WIDE_W'(i_minute_in);
            r_h     <= C_WIDE_W'(i_hour_in);
            r_d     <= C_WIDE_W'(i_day_in);
            r_month <= s_month_clamped;
            r_year  <= s_year_clamped;
        end else if (s_div_done) begin
            case (i_cmd.div_sel)
                DIV_SEC: begin
                    r_m   <= r_m + $signed(s_q60[C_WIDE_W-1:0]);
                    r_sec <= s_rem[5:0];
                end
                DIV_MIN: begin
                    r_h   <= r_h + $signed(s_q60[C_WIDE_W-1:0]);
                    r_min <= s_rem[5:0];
                end
                DIV_HOUR: begin
                    r_d  <= r_d + $signed(s_q24[C_WIDE_W-1:0]);
                    r_hr <= s_rem[4:0];
                end
                default: begin
                    r_ymod <= s_rem;
                end
            endcase
        end else if (i_cmd.walk) begin
            if (s_fwd_need) begin
                r_d <= r_d - $signed(C_WIDE_W'(s_dim_cur));
                if (r_month == C_MONTH_LAST) begin
                    r_month <= C_MONTH_FIRST;
                    r_year  <= r_year + C_YEAR_W'(1);
                    r_ymod  <= (r_ymod == C_YMOD_W'(C_YEAR_CYCLE - 1)) ? '0
                                                                       : r_ymod + C_YMOD_W'(1);
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else if (s_bwd_need) begin
                r_d     <= r_d + $signed(C_WIDE_W'(s_dim_bw));
                r_month <= s_bw_month;
                r_year  <= s_bw_year;
                r_ymod  <= s_bw_ymod;
            end
        end
    end

    // The walked year stays below twice the limit, so its top bit flags saturation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_year_out   <= r_year[C_YEAR_W-1] ? 15'(C_YEAR_MAX) : r_year[14:0];
            r_sat_out    <= r_year[C_YEAR_W-1];
            r_month_out  <= r_month;
            r_day_out    <= r_d[4:0];
            r_hour_out   <= r_hr;
            r_minute_out <= r_min;
            r_second_out <= r_sec;
        end
    end

    assign o_sts.div_done = s_div_done;
    assign o_sts.fwd_need = s_fwd_need;
    assign o_sts.bwd_need = s_bwd_need;

    assign o_year_out       = r_year_out;
    assign o_month_out      = r_month_out;
    assign o_day_out        = r_day_out;
    assign o_hour_out       = r_hour_out;
    assign o_minute_out     = r_minute_out;
    assign o_second_out     = r_second_out;
    assign o_year_saturated = r_sat_out;

endmodule

FILE: hdl/cdtn_ctrl.sv
// Controller: sequences the carries, the month walk and the result handshake.
`timescale 1ns / 1ps

module cdtn_ctrl import cdtn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_cdtn_sts i_sts,
    output t_cdtn_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state   r_state;
    t_div_sel r_sel;
    logic     r_out_valid;
    logic     s_out_free;

    assign s_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == ST_START);
        o_cmd.div_sel   = r_sel;
        o_cmd.walk      = (r_state == ST_WALK);
        o_cmd.out_load  = (r_state == ST_DONE) && s_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= DIV_SEC;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces one that leaves in the same cycle.
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= DIV_SEC;
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (i_sts.div_done) begin
                        case (r_sel)
                            DIV_SEC: begin
                                r_sel   <= DIV_MIN;
                                r_state <= ST_START;
                            end
                            DIV_MIN: begin
                                r_sel   <= DIV_HOUR;
                                r_state <= ST_START;
                            end
                            DIV_HOUR: begin
                                r_sel   <= DIV_YEAR;
                                r_state <= ST_START;
                            end
                            default: begin
                                r_state <= ST_WALK;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (!i_sts.fwd_need && !i_sts.bwd_need) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (s_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/calendar_date_time_normalizer_unit.sv
// Top level of the Gregorian date and time normaliser.
`timescale 1ns / 1ps

// The unit takes a signed date and time whose fields may lie outside their
// ranges and returns the same instant in normalised Gregorian form. As the
// item is taken in, the month is clamped to 1..12 and the year to at least 1.
// Seconds and minutes then carry at base 60 and hours at base 24 into the day,
// rounding towards minus infinity so that negative values borrow, and the day
// is walked month by month, forwards or backwards, until it fits its month;
// the year never drops below 1 on the way back. A walked year above 32767 is
// reported as 32767 with year_saturated set, the other fields keeping their
// walked values. Items are handled one at a time. An item is taken in, then
// goes through the three time carries and the year-modulo-400 step, which
// share one divider that multiplies by a fixed reciprocal over three
// registered stages, then through the month walk until the day fits its
// month, and last the result register is loaded. An item whose carried day
// lies near its extreme of some 34 000 days steps about 1 120 months. The
// result sits in an output register, so the next item is taken while a
// finished result still waits for its transfer; the following result then
// waits in its last step until the earlier one has been transferred.
module calendar_date_time_normalizer_unit import cdtn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdtn_in_if.sink     i_in,
    cdtn_out_if.source  o_out
);

    // Command and status between the sequencer and the datapath.
    t_cdtn_cmd s_cmd;
    t_cdtn_sts s_sts;

    // The controller owns both handshakes; the datapath only sees commands.
    cdtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    // The datapath holds the working values, the divider and the result register.
    cdtn_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_year_in        (i_in.year_in),
        .i_month_in       (i_in.month_in),
        .i_day_in         (i_in.day_in),
        .i_hour_in        (i_in.hour_in),
        .i_minute_in      (i_in.minute_in),
        .i_second_in      (i_in.second_in),
        .o_sts            (s_sts),
        .o_year_out       (o_out.year_out),
        .o_month_out      (o_out.month_out),
        .o_day_out        (o_out.day_out),
        .o_hour_out       (o_out.hour_out),
        .o_minute_out     (o_out.minute_out),
        .o_second_out     (o_out.second_out),
        .o_year_saturated (o_out.year_saturated)
    );

`ifndef ASSERT_OFF
    // Once an item is taken the unit is busy and takes no second one at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again directly after a transfer");

    // A presented result is always in its normalised ranges.
    a_result_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_out >= 4'd1) && (o_out.month_out <= 4'd12)
                     && (o_out.day_out >= 5'd1) && (o_out.hour_out <= 5'd23)
                     && (o_out.minute_out <= 6'd59) && (o_out.second_out <= 6'd59)
                     && (o_out.year_out != 15'd0))
        else $error("result outside its normalised range");

    // Saturation reports the year at its upper limit.
    a_saturation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.year_saturated) |-> (o_out.year_out == 15'h7fff))
        else $error("saturated year not at its limit");

    // The month walk is only commanded when no divider work is in flight.
    a_walk_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.walk |-> !s_cmd.div_start && !s_sts.div_done && !s_cmd.load)
        else $error("month walk overlaps a carry step");
`endif

endmodule
